@@ src/anc_hp_pkg.sv @@
// Shared types, constants and helpers for the high-pass ANC controller.
`timescale 1ns / 1ps

package anc_hp_pkg;

	// Defaults for the top-level parameters
	localparam int DAC_BIAS_DEF  = 2048;
	localparam int COEF_FRAC_DEF = 14;

	// Block averaging length, a power of two
	localparam int AVG_LEN    = 8;
	localparam int AVG_LOG2   = $clog2(AVG_LEN);
	localparam int AVG_CNT_W  = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
	localparam int ESUM_W     = 16 + AVG_LOG2;
	localparam int DSUM_W     = 12 + AVG_LOG2;

	// Multiplier operand, product and accumulator widths
	localparam int OP_W   = 16;
	localparam int PROD_W = 2 * OP_W;
	localparam int ACC_W  = PROD_W + 2;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_VAL_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HP_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HP_POLE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_COEF0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_COEF1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_COEF2 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRV_COEF1 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRV_COEF2 = 3'd7;

	// Register reset values
	localparam logic signed [OP_W-1:0] HP_GAIN_RST   = 16'sd16287;
	localparam logic signed [OP_W-1:0] HP_POLE_RST   = 16'sd16192;
	localparam logic signed [OP_W-1:0] ERR_COEF0_RST = 16'sd15861;
	localparam logic signed [OP_W-1:0] ERR_COEF1_RST = -16'sd27002;
	localparam logic signed [OP_W-1:0] ERR_COEF2_RST = 16'sd13804;
	localparam logic signed [OP_W-1:0] DRV_COEF1_RST = -16'sd5154;
	localparam logic signed [OP_W-1:0] DRV_COEF2_RST = 16'sd4099;

	localparam logic signed [15:0] PREV_INPUT_RST = 16'sd1973;

	// Accumulator operations
	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	typedef struct packed {
		logic [11:0] sample;
	} sample_t;

	typedef struct packed {
		logic [11:0]        dac_code;
		logic               dac_write;
		logic signed [15:0] error_value;
		logic signed [11:0] drive_value;
		logic               mean_valid;
		logic signed [15:0] mean_error;
		logic signed [11:0] mean_drive;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_VAL_W-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic                   enable;
		logic signed [OP_W-1:0] hp_gain;
		logic signed [OP_W-1:0] hp_pole;
		logic signed [OP_W-1:0] err_coef0;
		logic signed [OP_W-1:0] err_coef1;
		logic signed [OP_W-1:0] err_coef2;
		logic signed [OP_W-1:0] drv_coef1;
		logic signed [OP_W-1:0] drv_coef2;
	} coef_t;

	typedef struct packed {
		logic       mul_en;
		logic [1:0] acc_op;
	} mac_ctrl_t;

	// Divide by 2^sh, truncating toward zero
	function automatic logic signed [ACC_W-1:0] shr_trunc(
		input logic signed [ACC_W-1:0] v,
		input int unsigned             sh
	);
		logic signed [ACC_W-1:0] bias;
		bias = v[ACC_W-1] ? ACC_W'((64'd1 << sh) - 64'd1) : '0;
		return (v + bias) >>> sh;
	endfunction

endpackage

@@ src/anc_hp_stream_if.sv @@
// Valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps

interface anc_hp_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ src/anc_hp_regs.sv @@
// Configuration register file: enable and Q2.14 coefficients.
`timescale 1ns / 1ps

module anc_hp_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	anc_hp_stream_if.sink           cfg,
	output anc_hp_pkg::coef_t       coef
);

	anc_hp_pkg::coef_t coef_q;

	assign cfg.ready = 1'b1;
	assign coef      = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.enable    <= 1'b0;
			coef_q.hp_gain   <= anc_hp_pkg::HP_GAIN_RST;
			coef_q.hp_pole   <= anc_hp_pkg::HP_POLE_RST;
			coef_q.err_coef0 <= anc_hp_pkg::ERR_COEF0_RST;
			coef_q.err_coef1 <= anc_hp_pkg::ERR_COEF1_RST;
			coef_q.err_coef2 <= anc_hp_pkg::ERR_COEF2_RST;
			coef_q.drv_coef1 <= anc_hp_pkg::DRV_COEF1_RST;
			coef_q.drv_coef2 <= anc_hp_pkg::DRV_COEF2_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				anc_hp_pkg::REG_ENABLE:    coef_q.enable    <= cfg.data.value[0];
				anc_hp_pkg::REG_HP_GAIN:   coef_q.hp_gain   <= cfg.data.value;
				anc_hp_pkg::REG_HP_POLE:   coef_q.hp_pole   <= cfg.data.value;
				anc_hp_pkg::REG_ERR_COEF0: coef_q.err_coef0 <= cfg.data.value;
				anc_hp_pkg::REG_ERR_COEF1: coef_q.err_coef1 <= cfg.data.value;
				anc_hp_pkg::REG_ERR_COEF2: coef_q.err_coef2 <= cfg.data.value;
				anc_hp_pkg::REG_DRV_COEF1: coef_q.drv_coef1 <= cfg.data.value;
				anc_hp_pkg::REG_DRV_COEF2: coef_q.drv_coef2 <= cfg.data.value;
				default: ;
			endcase
		end
	end

endmodule

@@ src/anc_hp_mac.sv @@
// Shared 16x16 signed multiplier with registered product and accumulator.
`timescale 1ns / 1ps

module anc_hp_mac (
	input  logic                                        clk,
	input  anc_hp_pkg::mac_ctrl_t                       ctrl,
	input  logic signed [anc_hp_pkg::OP_W-1:0]          op_a,
	input  logic signed [anc_hp_pkg::OP_W-1:0]          op_b,
	output logic signed [anc_hp_pkg::ACC_W-1:0]         sum
);

	localparam int AW = anc_hp_pkg::ACC_W;

	logic signed [anc_hp_pkg::PROD_W-1:0] prod_q;
	logic signed [AW-1:0]                 acc_q;
	logic signed [AW-1:0]                 prod_ext;

	assign prod_ext = AW'(prod_q);
	assign sum      = acc_q + prod_ext;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= op_a * op_b;
		end
		case (ctrl.acc_op)
			anc_hp_pkg::ACC_LOAD: acc_q <= prod_ext;
			anc_hp_pkg::ACC_ADD:  acc_q <= sum;
			default: ;
		endcase
	end

endmodule

@@ src/anc_hp_seq.sv @@
// Step sequencer, filter state, averaging and result register.
`timescale 1ns / 1ps

module anc_hp_seq #(
	parameter int DAC_BIAS  = anc_hp_pkg::DAC_BIAS_DEF,
	parameter int COEF_FRAC = anc_hp_pkg::COEF_FRAC_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	anc_hp_stream_if.sink                          samples,
	anc_hp_stream_if.source                        results,
	input  anc_hp_pkg::coef_t                      coef,
	output anc_hp_pkg::mac_ctrl_t                  mac_ctrl,
	output logic signed [anc_hp_pkg::OP_W-1:0]     op_a,
	output logic signed [anc_hp_pkg::OP_W-1:0]     op_b,
	input  logic signed [anc_hp_pkg::ACC_W-1:0]    mac_sum
);

	localparam int AW     = anc_hp_pkg::ACC_W;
	localparam int CW     = anc_hp_pkg::AVG_CNT_W;
	localparam int ESW    = anc_hp_pkg::ESUM_W;
	localparam int DSW    = anc_hp_pkg::DSUM_W;

	localparam int DRV_LO_I = (-DAC_BIAS < -2048) ? -2048 : -DAC_BIAS;
	localparam int DRV_HI_I = (4095 - DAC_BIAS > 2047) ? 2047 : 4095 - DAC_BIAS;

	localparam logic signed [AW-1:0] E_MAX  = AW'(32767);
	localparam logic signed [AW-1:0] E_MIN  = AW'(-32768);
	localparam logic signed [AW-1:0] DRV_LO = AW'(DRV_LO_I);
	localparam logic signed [AW-1:0] DRV_HI = AW'(DRV_HI_I);

	// Sequencer steps, one multiply each except the last
	localparam logic [2:0] ST_HP_GAIN = 3'd0;
	localparam logic [2:0] ST_HP_POLE = 3'd1;
	localparam logic [2:0] ST_ERR1    = 3'd2;
	localparam logic [2:0] ST_ERR2    = 3'd3;
	localparam logic [2:0] ST_DRV1    = 3'd4;
	localparam logic [2:0] ST_DRV2    = 3'd5;
	localparam logic [2:0] ST_ERR0    = 3'd6;
	localparam logic [2:0] ST_FINISH  = 3'd7;

	logic        busy_q;
	logic [2:0]  step_q;

	logic signed [15:0] x_q;
	logic signed [15:0] e_q;
	logic signed [15:0] prev_q;
	logic signed [15:0] eh1_q;
	logic signed [15:0] eh2_q;
	logic signed [11:0] dh1_q;
	logic signed [11:0] dh2_q;
	logic signed [ESW-1:0] esum_q;
	logic signed [DSW-1:0] dsum_q;
	logic [CW-1:0]      cnt_q;

	logic                  rvalid_q;
	anc_hp_pkg::result_t   rdata_q;

	logic                  fire;
	logic                  last;
	logic signed [15:0]    diff;
	logic signed [AW-1:0]  q_scaled;
	logic signed [15:0]    e_sat;
	logic signed [11:0]    u_clamp;
	logic signed [11:0]    u;
	logic signed [13:0]    dac_sum;
	logic signed [ESW-1:0] esum_n;
	logic signed [DSW-1:0] dsum_n;
	logic signed [AW-1:0]  mean_e_full;
	logic signed [AW-1:0]  mean_d_full;
	anc_hp_pkg::result_t   res_n;

	assign samples.ready = !busy_q;
	assign results.valid = rvalid_q;
	assign results.data  = rdata_q;

	assign fire = busy_q && (step_q == ST_FINISH) && (!rvalid_q || results.ready);
	assign last = (cnt_q == CW'(anc_hp_pkg::AVG_LEN - 1));
	assign diff = x_q - prev_q;

	// Operand select and accumulator control per step
	always_comb begin
		op_a            = coef.hp_gain;
		op_b            = diff;
		mac_ctrl.mul_en = busy_q;
		mac_ctrl.acc_op = anc_hp_pkg::ACC_HOLD;
		case (step_q)
			ST_HP_GAIN: begin
				op_a = coef.hp_gain;
				op_b = diff;
			end
			ST_HP_POLE: begin
				op_a            = coef.hp_pole;
				op_b            = eh1_q;
				mac_ctrl.acc_op = anc_hp_pkg::ACC_LOAD;
			end
			ST_ERR1: begin
				op_a = coef.err_coef1;
				op_b = eh1_q;
			end
			ST_ERR2: begin
				op_a            = coef.err_coef2;
				op_b            = eh2_q;
				mac_ctrl.acc_op = anc_hp_pkg::ACC_LOAD;
			end
			ST_DRV1: begin
				op_a            = coef.drv_coef1;
				op_b            = 16'(dh1_q);
				mac_ctrl.acc_op = anc_hp_pkg::ACC_ADD;
			end
			ST_DRV2: begin
				op_a            = coef.drv_coef2;
				op_b            = 16'(dh2_q);
				mac_ctrl.acc_op = anc_hp_pkg::ACC_ADD;
			end
			ST_ERR0: begin
				op_a            = coef.err_coef0;
				op_b            = e_q;
				mac_ctrl.acc_op = anc_hp_pkg::ACC_ADD;
			end
			default: begin
				// hold product and accumulator while the result waits
				mac_ctrl.mul_en = 1'b0;
			end
		endcase
	end

	// Scale, saturate and form the result
	always_comb begin
		q_scaled = anc_hp_pkg::shr_trunc(mac_sum, COEF_FRAC);

		if (q_scaled > E_MAX)
			e_sat = 16'sh7fff;
		else if (q_scaled < E_MIN)
			e_sat = -16'sh8000;
		else
			e_sat = q_scaled[15:0];

		if (q_scaled > DRV_HI)
			u_clamp = DRV_HI[11:0];
		else if (q_scaled < DRV_LO)
			u_clamp = DRV_LO[11:0];
		else
			u_clamp = q_scaled[11:0];

		u       = coef.enable ? u_clamp : 12'sd0;
		dac_sum = 14'(u) + 14'(DAC_BIAS);

		esum_n      = esum_q + ESW'(e_q);
		dsum_n      = dsum_q + DSW'(u);
		mean_e_full = anc_hp_pkg::shr_trunc(AW'(esum_n), anc_hp_pkg::AVG_LOG2);
		mean_d_full = anc_hp_pkg::shr_trunc(AW'(dsum_n), anc_hp_pkg::AVG_LOG2);

		res_n.dac_code    = dac_sum[11:0];
		res_n.dac_write   = coef.enable;
		res_n.error_value = e_q;
		res_n.drive_value = u;
		res_n.mean_valid  = last;
		res_n.mean_error  = last ? mean_e_full[15:0] : 16'sd0;
		res_n.mean_drive  = last ? mean_d_full[11:0] : 12'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= ST_HP_GAIN;
			rvalid_q <= 1'b0;
			prev_q   <= anc_hp_pkg::PREV_INPUT_RST;
			eh1_q    <= '0;
			eh2_q    <= '0;
			dh1_q    <= '0;
			dh2_q    <= '0;
			esum_q   <= '0;
			dsum_q   <= '0;
			cnt_q    <= '0;
		end else begin
			if (samples.valid && samples.ready) begin
				busy_q <= 1'b1;
				step_q <= ST_HP_GAIN;
			end else if (busy_q && step_q != ST_FINISH) begin
				step_q <= step_q + 3'd1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end

			if (fire)
				rvalid_q <= 1'b1;
			else if (results.ready)
				rvalid_q <= 1'b0;

			if (fire) begin
				prev_q <= x_q;
				eh2_q  <= eh1_q;
				eh1_q  <= e_q;
				dh2_q  <= dh1_q;
				dh1_q  <= u;
				esum_q <= last ? '0 : esum_n;
				dsum_q <= last ? '0 : dsum_n;
				cnt_q  <= last ? '0 : cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready)
			x_q <= -$signed({4'b0000, samples.data.sample});
		if (busy_q && step_q == ST_ERR1)
			e_q <= e_sat;
		if (fire)
			rdata_q <= res_n;
	end

	// Steps advance by one while working
	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (step_q != ST_FINISH) |=> busy_q && (step_q == $past(step_q) + 3'd1))
		else $error("sequencer step skipped");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> busy_q && (step_q == ST_HP_GAIN))
		else $error("accepted beat did not start sequence");

	a_fire_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> results.valid)
		else $error("finished result not presented");

	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.data.dac_write |-> results.data.drive_value == 12'sd0)
		else $error("drive not zero while disabled");

endmodule

@@ src/anc_hilp_placeholder_unused.sv @@
// Top level of the high-pass ANC controller: register file, shared MAC and sequencer.
`timescale 1ns / 1ps

// Active noise control loop: negated ADC sample -> first-order high-pass
// (error) -> second-order IIR controller (drive) -> DAC code.
// Channels: samples (sink) takes one 12-bit ADC code per beat; results
// (source) gives one beat per sample with DAC code, write flag, error,
// drive and the block means every eighth sample; cfg (sink, always ready)
// writes enable and the seven Q2.14 coefficients by register index.
// A sample runs through the multiply steps and then a finish step. One
// 16x16 multiplier serves all seven products, one per cycle, so an item
// holds the block alone: samples.ready is low from the accept
// until the result is loaded into the output register.
// The output register frees the datapath: a new sample is taken while
// the previous result still waits. If results.ready stays low, the next
// item holds in its last step until the register empties.
// Reset: enable cleared, coefficients to their defaults, filter history,
// block sums and sample count cleared, previous input set to 1973.
// Write cfg only while the block is idle.
module anc_highpass_iir_controller_unit #(
	parameter int DAC_BIAS  = anc_hp_pkg::DAC_BIAS_DEF,
	parameter int COEF_FRAC = anc_hp_pkg::COEF_FRAC_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	anc_hp_stream_if.sink    samples,
	anc_hp_stream_if.source  results,
	anc_hp_stream_if.sink    cfg
);

	anc_hp_pkg::coef_t                         coef;
	anc_hp_pkg::mac_ctrl_t                     mac_ctrl;
	logic signed [anc_hp_pkg::OP_W-1:0]        op_a;
	logic signed [anc_hp_pkg::OP_W-1:0]        op_b;
	logic signed [anc_hp_pkg::ACC_W-1:0]       mac_sum;

	anc_hp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef)
	);

	anc_hp_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a (op_a),
		.op_b (op_b),
		.sum  (mac_sum)
	);

	anc_hp_seq #(
		.DAC_BIAS  (DAC_BIAS),
		.COEF_FRAC (COEF_FRAC)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.results  (results),
		.coef     (coef),
		.mac_ctrl (mac_ctrl),
		.op_a     (op_a),
		.op_b     (op_b),
		.mac_sum  (mac_sum)
	);

endmodule
